/* rtl/core/prm_pkg.sv */
// Shared types, constants and coefficients of the three-axis pseudo-rate modulator.
// No dependencies; every other file in rtl/core imports this package.
package prm_pkg;

  // Fixed-point format of all levels, thresholds and commands.
  localparam int VAL_W     = 24;
  localparam int FRAC_BITS = 16;
  localparam int NUM_AXES  = 3;

  // Width of the error and of the negated threshold: one guard bit so neither wraps.
  localparam int ERR_W  = VAL_W + 1;
  // Decay coefficient is unsigned with FRAC_BITS fraction bits, below one.
  localparam int COEF_W = FRAC_BITS + 1;
  // Exact product of a level and the decay coefficient.
  localparam int PROD_W = VAL_W + COEF_W;
  // Decayed level plus or minus the kick, wide enough to detect saturation.
  localparam int SUM_W  = VAL_W + 2;

  // Coefficients rounded to the nearest step at elaboration.
  localparam longint unsigned COEF_A_INT =
    (64'd9231 * (64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned COEF_B_INT =
    (64'd7688 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [COEF_W-1:0]       COEF_A = COEF_W'(COEF_A_INT);
  localparam logic signed [SUM_W-1:0] COEF_B = SUM_W'(COEF_B_INT);

  // Saturation bounds of a level.
  localparam logic signed [SUM_W-1:0] LVL_MAX = SUM_W'((64'd1 << (VAL_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] LVL_MIN = -SUM_W'(64'd1 << (VAL_W - 1));

  // Valve drive codes.
  localparam logic [3:0] DRIVE_ON  = 4'hF;
  localparam logic [3:0] DRIVE_OFF = 4'h0;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_AXIS0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_AXIS1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_AXIS2 = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // One request: a command sample per axis.
  typedef struct packed {
    val_t command_axis0;
    val_t command_axis1;
    val_t command_axis2;
  } in_item_t;

  // One result: positive and negative valve codes per axis.
  typedef struct packed {
    logic [3:0] pos_drive_axis0;
    logic [3:0] neg_drive_axis0;
    logic [3:0] pos_drive_axis1;
    logic [3:0] neg_drive_axis1;
    logic [3:0] pos_drive_axis2;
    logic [3:0] neg_drive_axis2;
  } out_item_t;

  // Valve pair of one axis.
  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] neg;
  } drive_t;

endpackage

/* rtl/core/prm_cfg_regs.sv */
// Threshold registers of the pseudo-rate modulator, written through the configuration port.
// Depends on prm_pkg.
module prm_cfg_regs
  import prm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  val_t                 cfg_data,
  output val_t                 threshold [NUM_AXES]
);

  val_t thr_r [NUM_AXES];

  // Writes complete at once; an index past the last register is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        thr_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD_AXIS0: thr_r[0] <= cfg_data;
        CFG_THRESHOLD_AXIS1: thr_r[1] <= cfg_data;
        CFG_THRESHOLD_AXIS2: thr_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign threshold = thr_r;

endmodule

/* rtl/core/prm_axis.sv */
// Per-axis datapath: error, firing decision and next feedback level.
// Depends on prm_pkg.
module prm_axis
  import prm_pkg::*;
(
  input  val_t   command,
  input  val_t   level,
  input  val_t   threshold,
  output drive_t drive,
  output val_t   level_nxt
);

  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  thr_pos;
  logic signed [ERR_W-1:0]  thr_neg;
  logic signed [PROD_W-1:0] lvl_ext;
  logic signed [PROD_W-1:0] coef_ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  decayed;
  logic signed [SUM_W-1:0]  sum;

  // Error and both thresholds at full precision.
  assign err     = ERR_W'(command) - ERR_W'(level);
  assign thr_pos = ERR_W'(threshold);
  assign thr_neg = -thr_pos;

  // Decay: exact product, then arithmetic shift (floor).
  assign lvl_ext  = PROD_W'(level);
  assign coef_ext = PROD_W'(COEF_A);
  assign prod     = lvl_ext * coef_ext;
  assign decayed  = SUM_W'(prod >>> FRAC_BITS);

  // Firing decision; the upper test takes priority over the lower one.
  always_comb begin
    drive.pos = DRIVE_OFF;
    drive.neg = DRIVE_OFF;
    sum       = decayed;
    if (err > thr_pos) begin
      drive.neg = DRIVE_ON;
      sum       = decayed + COEF_B;
    end else if (err < thr_neg) begin
      drive.pos = DRIVE_ON;
      sum       = decayed - COEF_B;
    end
  end

  // Saturate the new level to the value range.
  always_comb begin
    if (sum > LVL_MAX) begin
      level_nxt = VAL_W'(LVL_MAX);
    end else if (sum < LVL_MIN) begin
      level_nxt = VAL_W'(LVL_MIN);
    end else begin
      level_nxt = VAL_W'(sum);
    end
  end

endmodule

/* rtl/core/pseudo_rate_modulator_3axis_core.sv */
// Three-axis pseudo-rate modulator for on-off thruster valves.
// Depends on prm_pkg, prm_cfg_regs and prm_axis.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request holding a
//   signed Q8.16 command per axis. Result channel (out_valid/out_ready/
//   out_data) returns one result per request: a positive and a negative
//   valve code per axis, 15 for on and 0 for off.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
//   per-axis firing thresholds; cfg_ready is always high, unknown indexes are
//   dropped. The user must change thresholds only while the block is idle;
//   the block itself does not enforce this. An accepted request waits in the
//   input register, is evaluated against the feedback levels and moves into
//   the result register (out_valid) once it is free or draining. Throughput:
//   one request per cycle unless stalled; the feedback update is a single
//   multiply-add per axis between the input register and the result register.
//   Reset (rst_n low at a clock edge) clears thresholds, feedback levels and
//   both valid flags. When the receiver stalls, the result register holds
//   and one more request waits in the input register before in_ready drops.
module pseudo_rate_modulator_3axis_core
  import prm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  val_t                 cfg_data
);

  val_t      threshold [NUM_AXES];
  val_t      command   [NUM_AXES];
  val_t      lvl_r     [NUM_AXES];
  val_t      lvl_nxt   [NUM_AXES];
  drive_t    drive     [NUM_AXES];
  in_item_t  in_q_r;
  logic      in_valid_r;
  out_item_t out_q_r;
  out_item_t out_q_nxt;
  logic      out_valid_r;
  logic      advance;

  prm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .threshold (threshold)
  );

  // The held request moves on when the result register is free or draining.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
  end

  // Per-axis datapaths.
  assign command[0] = in_q_r.command_axis0;
  assign command[1] = in_q_r.command_axis1;
  assign command[2] = in_q_r.command_axis2;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
    prm_axis u_axis (
      .command   (command[g]),
      .level     (lvl_r[g]),
      .threshold (threshold[g]),
      .drive     (drive[g]),
      .level_nxt (lvl_nxt[g])
    );
  end

  // Feedback levels update once per evaluated request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (advance) begin
      lvl_r <= lvl_nxt;
    end
  end

  // Pack the valve codes into a result.
  always_comb begin
    out_q_nxt.pos_drive_axis0 = drive[0].pos;
    out_q_nxt.neg_drive_axis0 = drive[0].neg;
    out_q_nxt.pos_drive_axis1 = drive[1].pos;
    out_q_nxt.neg_drive_axis1 = drive[1].neg;
    out_q_nxt.pos_drive_axis2 = drive[2].pos;
    out_q_nxt.neg_drive_axis2 = drive[2].neg;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q_r <= out_q_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

endmodule
